### rtl/skf_pkg.sv
package skf_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int COV_W      = DATA_WIDTH - 1;
    localparam int WIDE_W     = 2 * DATA_WIDTH;
    localparam int DIV_STEPS  = DATA_WIDTH + FRAC_BITS;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    typedef logic signed [DATA_WIDTH-1:0] data_t;
    typedef logic        [COV_W-1:0]      cov_t;

    localparam data_t DATA_MAX = data_t'({1'b0, {(DATA_WIDTH-1){1'b1}}});
    localparam data_t DATA_MIN = data_t'({1'b1, {(DATA_WIDTH-1){1'b0}}});
    localparam data_t ONE_Q    = data_t'(1 << FRAC_BITS);

    // register indexes on the cfg channel
    typedef enum logic [2:0] {
        REG_STATE_FACTOR       = 3'd0,
        REG_MEASURE_FACTOR     = 3'd1,
        REG_PROCESS_NOISE      = 3'd2,
        REG_MEASUREMENT_NOISE  = 3'd3,
        REG_INITIAL_ESTIMATE   = 3'd4,
        REG_INITIAL_COVARIANCE = 3'd5
    } reg_index_t;

    // post-multiply combine codes
    localparam logic [1:0] ADD_NONE  = 2'd0;  // r = m
    localparam logic [1:0] ADD_PLUS  = 2'd1;  // r = m + c
    localparam logic [1:0] ADD_MINUS = 2'd2;  // r = c - m

    typedef struct packed {
        logic [1:0] add_sel;
        logic       clip_neg;
    } alu_op_t;

    typedef struct packed {
        logic  sat;
        data_t val;
    } fit_t;

    // saturate a wide signed value to the data range
    function automatic fit_t clamp_wide(input logic signed [WIDE_W-1:0] v);
        fit_t                         r;
        logic [WIDE_W-DATA_WIDTH:0]   top;
        top = v[WIDE_W-1:DATA_WIDTH-1];
        if ((&top) || !(|top))
        begin
            r.sat = 1'b0;
            r.val = data_t'(v[DATA_WIDTH-1:0]);
        end
        else
        begin
            r.sat = 1'b1;
            r.val = v[WIDE_W-1] ? DATA_MIN : DATA_MAX;
        end
        return r;
    endfunction

endpackage

### rtl/skf_alu.sv
module skf_alu (
    input  logic             clk,
    input  skf_pkg::alu_op_t op,
    input  skf_pkg::data_t   a,
    input  skf_pkg::data_t   b,
    input  skf_pkg::data_t   c,
    output skf_pkg::fit_t    res
);
    import skf_pkg::*;

    logic signed [WIDE_W-1:0] prod_reg;
    logic signed [WIDE_W-1:0] prod_next;
    alu_op_t                  op_reg;
    data_t                    c_reg;

    logic signed [WIDE_W-1:0]   shifted;
    fit_t                       mfit;
    fit_t                       sfit;
    logic signed [DATA_WIDTH:0] sum;

    assign prod_next = a * b;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        op_reg   <= op;
        c_reg    <= c;
    end

    // floor(prod / 2^FRAC_BITS), clamp, optional add/sub, clamp, clip
    always_comb
    begin
        shifted = prod_reg >>> FRAC_BITS;
        mfit    = clamp_wide(shifted);
        case (op_reg.add_sel)
            ADD_PLUS:  sum = {mfit.val[DATA_WIDTH-1], mfit.val} + {c_reg[DATA_WIDTH-1], c_reg};
            ADD_MINUS: sum = {c_reg[DATA_WIDTH-1], c_reg} - {mfit.val[DATA_WIDTH-1], mfit.val};
            default:   sum = {mfit.val[DATA_WIDTH-1], mfit.val};
        endcase
        sfit    = clamp_wide(WIDE_W'(sum));
        res.val = sfit.val;
        res.sat = mfit.sat | sfit.sat;
        if (op_reg.clip_neg && sfit.val[DATA_WIDTH-1])
        begin
            res.val = '0;
            res.sat = 1'b1;
        end
    end

endmodule

### rtl/skf_div.sv
module skf_div (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  skf_pkg::data_t num,
    input  skf_pkg::data_t den,
    output logic           done,
    output skf_pkg::fit_t  quo
);
    import skf_pkg::*;

    logic                     busy_reg;
    logic                     done_reg;
    logic [DIV_CNT_W-1:0]     cnt_reg;
    logic [DATA_WIDTH-2:0]    rem_reg;
    logic [DIV_STEPS-1:0]     quo_reg;
    logic [DATA_WIDTH-2:0]    dvs_reg;
    logic                     neg_reg;

    logic [DATA_WIDTH-1:0]    num_mag;
    logic [DATA_WIDTH-1:0]    trial;
    logic [DATA_WIDTH-1:0]    diff;
    logic                     ge;
    logic [DATA_WIDTH-2:0]    rem_next;
    logic signed [WIDE_W-1:0] qw;

    assign num_mag  = num[DATA_WIDTH-1] ? DATA_WIDTH'(-num) : DATA_WIDTH'(num);
    assign trial    = {rem_reg, quo_reg[DIV_STEPS-1]};
    assign diff     = trial - {1'b0, dvs_reg};
    assign ge       = trial >= {1'b0, dvs_reg};
    assign rem_next = ge ? diff[DATA_WIDTH-2:0] : trial[DATA_WIDTH-2:0];

    // restoring divide, one quotient bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
            dvs_reg  <= '0;
            neg_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_STEPS - 1);
                rem_reg  <= '0;
                quo_reg  <= {num_mag, FRAC_BITS'(0)};
                dvs_reg  <= den[DATA_WIDTH-2:0];
                neg_reg  <= num[DATA_WIDTH-1];
            end
            else if (busy_reg)
            begin
                rem_reg <= rem_next;
                quo_reg <= {quo_reg[DIV_STEPS-2:0], ge};
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    assign qw   = $signed(WIDE_W'(quo_reg));
    assign quo  = clamp_wide(neg_reg ? -qw : qw);
    assign done = done_reg;

endmodule

### rtl/scalar_kalman_filter.sv
// One-dimensional Kalman filter, signed Q16.16. Each measurement transfer on
// the s_axis side runs one predict/correct step on the held estimate and
// covariance and yields one result transfer on m_axis carrying the new
// estimate and covariance, the predictions, the gain and two flags. All math
// goes through one shared 32x32 multiplier with a saturating add/sub behind
// it (nine products) plus a bit-serial divider for the gain (48 quotient
// bits, one per cycle). The divide is skipped when the gain denominator is
// zero or negative. s_axis_tready is high only between steps; a finished
// result sits in the output register so the next measurement can be taken
// while it waits. Writing initial_estimate or initial_covariance also loads
// the running state; config writes are for idle time only.
module scalar_kalman_filter (
    input  logic         clk,
    input  logic         rst_n,
    // measurement input
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,   // [31:0] measurement
    // results
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [31:0] estimate, [62:32] error_covariance, [94:63] predicted_estimate,
    // [125:95] predicted_covariance, [157:126] kalman_gain, [159:158] zero
    output logic [159:0] m_axis_tdata,
    output logic [1:0]   m_axis_tuser,   // [0] saturated, [1] zero_denominator
    // register writes
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    import skf_pkg::*;

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;  // operands into multiplier
    localparam logic [2:0] ST_ACC  = 3'd2;  // floored/combined result back
    localparam logic [2:0] ST_DIV  = 3'd3;  // waiting on gain divide
    localparam logic [2:0] ST_OUT  = 3'd4;  // hand result to output reg

    // arithmetic steps, in issue order
    localparam logic [3:0] SP_X0  = 4'd0;  // x0 = F*est
    localparam logic [3:0] SP_FF  = 4'd1;  // ff = F*F
    localparam logic [3:0] SP_P0  = 4'd2;  // p0 = max(ff*cov + Q, 0)
    localparam logic [3:0] SP_HP  = 4'd3;  // hp = H*p0
    localparam logic [3:0] SP_DEN = 4'd4;  // den = hp*H + R
    localparam logic [3:0] SP_HX  = 4'd5;  // innov = z - H*x0
    localparam logic [3:0] SP_EST = 4'd6;  // est = x0 + K*innov
    localparam logic [3:0] SP_KH  = 4'd7;  // omk = 1 - K*H
    localparam logic [3:0] SP_COV = 4'd8;  // cov = max(omk*p0, 0)

    logic [2:0] state_reg;
    logic [3:0] step_reg;

    // configuration
    data_t f_reg;
    data_t h_reg;
    cov_t  q_reg;
    cov_t  r_reg;

    // filter state and per-step working values
    data_t est_reg;
    cov_t  cov_reg;
    data_t z_reg;
    data_t x0_reg;
    data_t ff_reg;
    cov_t  p0_reg;
    data_t hp_reg;
    data_t k_reg;
    data_t innov_reg;
    data_t omk_reg;
    logic  sat_reg;
    logic  zd_reg;

    // output register
    logic  out_valid_reg;
    data_t out_est_reg;
    cov_t  out_cov_reg;
    data_t out_x0_reg;
    cov_t  out_p0_reg;
    data_t out_k_reg;
    logic  out_sat_reg;
    logic  out_zd_reg;

    // shared unit hookup
    alu_op_t alu_op;
    data_t   alu_a;
    data_t   alu_b;
    data_t   alu_c;
    fit_t    alu_res;

    logic    div_start;
    logic    div_done;
    fit_t    div_quo;
    logic    den_le0;

    logic       acc_sat;
    logic [2:0] acc_state;
    logic       out_load;

    skf_alu u_alu (
        .clk (clk),
        .op  (alu_op),
        .a   (alu_a),
        .b   (alu_b),
        .c   (alu_c),
        .res (alu_res)
    );

    skf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (hp_reg),
        .den   (alu_res.val),
        .done  (div_done),
        .quo   (div_quo)
    );

    // operand select per step
    always_comb
    begin
        alu_a  = f_reg;
        alu_b  = est_reg;
        alu_c  = '0;
        alu_op = '{add_sel: ADD_NONE, clip_neg: 1'b0};
        case (step_reg)
            SP_X0:
            begin
                alu_a = f_reg;
                alu_b = est_reg;
            end
            SP_FF:
            begin
                alu_a = f_reg;
                alu_b = f_reg;
            end
            SP_P0:
            begin
                alu_a  = ff_reg;
                alu_b  = data_t'({1'b0, cov_reg});
                alu_c  = data_t'({1'b0, q_reg});
                alu_op = '{add_sel: ADD_PLUS, clip_neg: 1'b1};
            end
            SP_HP:
            begin
                alu_a = h_reg;
                alu_b = data_t'({1'b0, p0_reg});
            end
            SP_DEN:
            begin
                alu_a  = hp_reg;
                alu_b  = h_reg;
                alu_c  = data_t'({1'b0, r_reg});
                alu_op = '{add_sel: ADD_PLUS, clip_neg: 1'b0};
            end
            SP_HX:
            begin
                alu_a  = h_reg;
                alu_b  = x0_reg;
                alu_c  = z_reg;
                alu_op = '{add_sel: ADD_MINUS, clip_neg: 1'b0};
            end
            SP_EST:
            begin
                alu_a  = k_reg;
                alu_b  = innov_reg;
                alu_c  = x0_reg;
                alu_op = '{add_sel: ADD_PLUS, clip_neg: 1'b0};
            end
            SP_KH:
            begin
                alu_a  = k_reg;
                alu_b  = h_reg;
                alu_c  = ONE_Q;
                alu_op = '{add_sel: ADD_MINUS, clip_neg: 1'b0};
            end
            SP_COV:
            begin
                alu_a  = omk_reg;
                alu_b  = data_t'({1'b0, p0_reg});
                alu_op = '{add_sel: ADD_NONE, clip_neg: 1'b1};
            end
            default:
            begin
                alu_a = f_reg;
                alu_b = est_reg;
            end
        endcase
    end

    // non-positive denominator: gain forced to zero, no divide
    assign den_le0   = alu_res.val[DATA_WIDTH-1] || (alu_res.val == '0);
    assign div_start = (state_reg == ST_ACC) && (step_reg == SP_DEN) && !den_le0;

    // where the sequencer goes after a result comes back
    always_comb
    begin
        case (step_reg)
            SP_X0, SP_FF, SP_P0, SP_HP, SP_HX, SP_EST, SP_KH: acc_state = ST_MUL;
            SP_DEN:  acc_state = den_le0 ? ST_MUL : ST_DIV;
            SP_COV:  acc_state = ST_OUT;
            default: acc_state = ST_IDLE;
        endcase
    end

    // a negative denominator counts as a clamp
    assign acc_sat  = sat_reg | alu_res.sat |
                      ((step_reg == SP_DEN) && alu_res.val[DATA_WIDTH-1]);
    // load once the previous result has been taken
    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || m_axis_tready);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= SP_X0;
            f_reg         <= ONE_Q;
            h_reg         <= ONE_Q;
            q_reg         <= cov_t'(ONE_Q);
            r_reg         <= cov_t'(ONE_Q);
            est_reg       <= '0;
            cov_reg       <= cov_t'(ONE_Q);
            z_reg         <= '0;
            x0_reg        <= '0;
            ff_reg        <= '0;
            p0_reg        <= '0;
            hp_reg        <= '0;
            k_reg         <= '0;
            innov_reg     <= '0;
            omk_reg       <= '0;
            sat_reg       <= 1'b0;
            zd_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            out_est_reg   <= '0;
            out_cov_reg   <= '0;
            out_x0_reg    <= '0;
            out_p0_reg    <= '0;
            out_k_reg     <= '0;
            out_sat_reg   <= 1'b0;
            out_zd_reg    <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        z_reg     <= data_t'(s_axis_tdata);
                        sat_reg   <= 1'b0;
                        zd_reg    <= 1'b0;
                        step_reg  <= SP_X0;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    state_reg <= ST_ACC;
                end
                ST_ACC:
                begin
                    sat_reg   <= acc_sat;
                    step_reg  <= step_reg + 4'd1;
                    state_reg <= acc_state;
                    case (step_reg)
                        SP_X0:  x0_reg    <= alu_res.val;
                        SP_FF:  ff_reg    <= alu_res.val;
                        SP_P0:  p0_reg    <= alu_res.val[COV_W-1:0];
                        SP_HP:  hp_reg    <= alu_res.val;
                        SP_DEN:
                        begin
                            if (den_le0)
                            begin
                                k_reg  <= '0;
                                zd_reg <= !alu_res.val[DATA_WIDTH-1];
                            end
                        end
                        SP_HX:  innov_reg <= alu_res.val;
                        SP_EST: est_reg   <= alu_res.val;
                        SP_KH:  omk_reg   <= alu_res.val;
                        SP_COV: cov_reg   <= alu_res.val[COV_W-1:0];
                        default: ;
                    endcase
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        k_reg     <= div_quo.val;
                        sat_reg   <= sat_reg | div_quo.sat;
                        state_reg <= ST_MUL;
                    end
                end
                ST_OUT:
                begin
                    if (out_load)
                    begin
                        out_est_reg   <= est_reg;
                        out_cov_reg   <= cov_reg;
                        out_x0_reg    <= x0_reg;
                        out_p0_reg    <= p0_reg;
                        out_k_reg     <= k_reg;
                        out_sat_reg   <= sat_reg;
                        out_zd_reg    <= zd_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase

            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_STATE_FACTOR:       f_reg <= data_t'(cfg_data);
                    REG_MEASURE_FACTOR:     h_reg <= data_t'(cfg_data);
                    REG_PROCESS_NOISE:      q_reg <= cfg_data[COV_W-1:0];
                    REG_MEASUREMENT_NOISE:  r_reg <= cfg_data[COV_W-1:0];
                    REG_INITIAL_ESTIMATE:   est_reg <= data_t'(cfg_data);
                    REG_INITIAL_COVARIANCE: cov_reg <= cfg_data[COV_W-1:0];
                    default:                ;
                endcase
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_k_reg, out_p0_reg, out_x0_reg, out_cov_reg, out_est_reg};
    assign m_axis_tuser  = {out_zd_reg, out_sat_reg};

endmodule
